// ===== hw/rtl/kvmsc_pkg.sv =====
// Shared types and constants of the metadata section checker.
package kvmsc_pkg;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TYPE       = 3'd1,
      ST_KEY_CHAR   = 3'd2,
      ST_KEY_LONG   = 3'd3,
      ST_VALUE_LONG = 3'd4,
      ST_LENGTH     = 3'd5,
      ST_PAIRS      = 3'd6
   } status_type;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      REG_TYPE_CODE   = 2'd0,
      REG_KEY_LIMIT   = 2'd1,
      REG_VALUE_LIMIT = 2'd2,
      REG_PAIR_LIMIT  = 2'd3
   } reg_index_type;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Header layout: one type byte and four length bytes.
   localparam logic [2:0] HDR_BODY = 3'd5;

   // Reset values of the registers.
   localparam logic [7:0]  TYPE_CODE_RST   = 8'd0;
   localparam logic [7:0]  KEY_LIMIT_RST   = 8'd32;
   localparam logic [15:0] VALUE_LIMIT_RST = 16'd256;
   localparam logic [15:0] PAIR_LIMIT_RST  = 16'd64;

   localparam logic [7:0]  CHAR_LOW_A = 8'h61;
   localparam logic [7:0]  CHAR_LOW_Z = 8'h7A;
   localparam logic [7:0]  CHAR_UP_A  = 8'h41;
   localparam logic [7:0]  CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0]  KEY_SAT    = 8'hFF;
   localparam logic [15:0] COUNT_SAT  = 16'hFFFF;

   // Configuration as seen by the checker core.
   typedef struct packed {
      logic [7:0]  type_code;
      logic [7:0]  key_limit;
      logic [15:0] value_limit;
      logic [15:0] pair_limit;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic [15:0] pair_total;
      status_type  status;
   } result_type;

   // True for an ASCII letter.
   function automatic logic is_letter(input logic [7:0] b);
      return ((b >= CHAR_LOW_A) && (b <= CHAR_LOW_Z)) ||
             ((b >= CHAR_UP_A) && (b <= CHAR_UP_Z));
   endfunction

endpackage

// ===== hw/rtl/kvmsc_csr.sv =====
// Configuration register file of the metadata section checker.
module kvmsc_csr
   import kvmsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          wr_en;

   assign index = reg_index_type'(csr_paddr[3:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   // Register writes at the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.type_code   <= TYPE_CODE_RST;
         cfg_ff.key_limit   <= KEY_LIMIT_RST;
         cfg_ff.value_limit <= VALUE_LIMIT_RST;
         cfg_ff.pair_limit  <= PAIR_LIMIT_RST;
      end else if (wr_en) begin
         unique case (index)
            REG_TYPE_CODE:   cfg_ff.type_code   <= csr_pwdata[7:0];
            REG_KEY_LIMIT:   cfg_ff.key_limit   <= csr_pwdata[7:0];
            REG_VALUE_LIMIT: cfg_ff.value_limit <= csr_pwdata[15:0];
            REG_PAIR_LIMIT:  cfg_ff.pair_limit  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read-back mux.
   always_comb begin
      unique case (index)
         REG_TYPE_CODE:   csr_prdata = {24'd0, cfg_ff.type_code};
         REG_KEY_LIMIT:   csr_prdata = {24'd0, cfg_ff.key_limit};
         REG_VALUE_LIMIT: csr_prdata = {16'd0, cfg_ff.value_limit};
         REG_PAIR_LIMIT:  csr_prdata = {16'd0, cfg_ff.pair_limit};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/kvmsc_core.sv =====
// Parse state and per-byte check logic of the metadata section checker.
module kvmsc_core
   import kvmsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output result_type result
);

   logic [2:0]  header_pos_ff,  header_pos_in;
   logic        in_value_ff,    in_value_in;
   logic [7:0]  key_count_ff,   key_count_in;
   logic [15:0] value_count_ff, value_count_in;
   logic [15:0] pair_count_ff,  pair_count_in;
   logic        bad_char_ff,    bad_char_in;
   status_type  first_error_ff, first_error_in;

   // Next parse state for the byte at hand; nothing moves once an error is held.
   always_comb begin
      header_pos_in  = header_pos_ff;
      in_value_in    = in_value_ff;
      key_count_in   = key_count_ff;
      value_count_in = value_count_ff;
      pair_count_in  = pair_count_ff;
      bad_char_in    = bad_char_ff;
      first_error_in = first_error_ff;
      if (first_error_ff == ST_OK) begin
         if (header_pos_ff < HDR_BODY) begin
            // Header: type byte, then length bytes that are skipped.
            if ((header_pos_ff == 3'd0) && (data_byte != cfg.type_code)) begin
               first_error_in = ST_TYPE;
            end
            header_pos_in = header_pos_ff + 3'd1;
            if (last_byte && (first_error_in == ST_OK)) begin
               first_error_in = ST_LENGTH;
            end
         end else if (!in_value_ff) begin
            // Key phase.
            if (data_byte == 8'd0) begin
               in_value_in    = 1'b1;
               value_count_in = '0;
            end else begin
               if (!is_letter(data_byte)) begin
                  bad_char_in = 1'b1;
               end
               if (key_count_ff != KEY_SAT) begin
                  key_count_in = key_count_ff + 8'd1;
               end
            end
            // The key is judged at its terminator or where the blob ends.
            if ((data_byte == 8'd0) || last_byte) begin
               if (bad_char_in) begin
                  first_error_in = ST_KEY_CHAR;
               end else if (key_count_in >= cfg.key_limit) begin
                  first_error_in = ST_KEY_LONG;
               end
            end
            if (last_byte && (first_error_in == ST_OK)) begin
               first_error_in = ST_LENGTH;
            end
         end else if (data_byte == 8'd0) begin
            // Value terminator closes a pair.
            if (value_count_ff >= cfg.value_limit) begin
               first_error_in = ST_VALUE_LONG;
            end else begin
               if (pair_count_ff != COUNT_SAT) begin
                  pair_count_in = pair_count_ff + 16'd1;
               end
               in_value_in  = 1'b0;
               key_count_in = '0;
               bad_char_in  = 1'b0;
               if (last_byte && (pair_count_in > cfg.pair_limit)) begin
                  first_error_in = ST_PAIRS;
               end
            end
         end else begin
            // Value byte.
            if (value_count_ff != COUNT_SAT) begin
               value_count_in = value_count_ff + 16'd1;
            end
            if (last_byte) begin
               first_error_in = (value_count_in >= cfg.value_limit) ?
                                ST_VALUE_LONG : ST_LENGTH;
            end
         end
      end
   end

   // State registers; the last byte of a blob starts a fresh parse.
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         header_pos_ff  <= '0;
         in_value_ff    <= 1'b0;
         key_count_ff   <= '0;
         value_count_ff <= '0;
         pair_count_ff  <= '0;
         bad_char_ff    <= 1'b0;
         first_error_ff <= ST_OK;
      end else if (step) begin
         header_pos_ff  <= header_pos_in;
         in_value_ff    <= in_value_in;
         key_count_ff   <= key_count_in;
         value_count_ff <= value_count_in;
         pair_count_ff  <= pair_count_in;
         bad_char_ff    <= bad_char_in;
         first_error_ff <= first_error_in;
      end
   end

   assign result.status     = first_error_in;
   assign result.pair_total = pair_count_in;

   // The header position never runs past the body marker.
   a_hdr_range: assert property (@(posedge clock) disable iff (reset)
      header_pos_ff <= HDR_BODY)
      else $error("header position out of range");

   // Phase and counters only move once the header is done.
   a_hdr_phase: assert property (@(posedge clock) disable iff (reset)
      (header_pos_ff < HDR_BODY) |-> (!in_value_ff && (key_count_ff == 8'd0)
                                      && (pair_count_ff == 16'd0)))
      else $error("body state changed inside the header");

   // A held error freezes the parse state.
   a_err_hold: assert property (@(posedge clock) disable iff (reset)
      (step && !last_byte && (first_error_ff != ST_OK)) |=>
      ($stable(pair_count_ff) && $stable(first_error_ff)))
      else $error("state moved after an error");

endmodule

// ===== hw/rtl/kv_metadata_section_checker.sv =====
// Top level of the metadata section checker: input register, check core, result register.
// Throughput: one byte per cycle; the input register feeds the single-pass check logic,
// which writes the result register on the last byte of a blob.
// A byte stalls in the input register only while it is a last byte and the result
// register holds an untaken result.
// Reset (synchronous, active high) empties both registers, clears the parse state
// and loads the configuration defaults.
module kv_metadata_section_checker
   import kvmsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // last_byte
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [2:0] status, [18:3] pair_total, zeros above
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   result_type result;

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       out_valid_ff;
   result_type out_result_ff;
   logic       out_free;
   logic       s1_fire;

   kvmsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   assign csr_pready = 1'b1;

   // Handshake: a byte leaves the input register unless it must wait for the result slot.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_fire;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   kvmsc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (s1_fire),
      .data_byte (s1_byte_ff),
      .last_byte (s1_last_ff),
      .result    (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_fire && s1_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_result_ff.pair_total, out_result_ff.status};

   // A new result only appears after a last byte went through the core.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_fire && s1_last_ff))
      else $error("result without a last item");

   // A last byte waits while the result slot is full and not being drained.
   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff && out_valid_ff && !rsp_tready) |=> s1_valid_ff)
      else $error("last item dropped while result slot was busy");

   // A type error happens in the header, before any pair is counted.
   a_type_pairs: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_result_ff.status == ST_TYPE)) |->
      (out_result_ff.pair_total == 16'd0))
      else $error("pairs counted with a type error");

   // The status code stays within the defined codes.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_result_ff.status <= ST_PAIRS))
      else $error("status code out of range");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the metadata section checker.
`timescale 1ns / 100ps

module testbench;
   import kvmsc_pkg::*;

   localparam int     PHASES        = 6;
   localparam int     PHASE_BYTES   = 140;
   localparam longint RUN_LIMIT_NS  = 5_000_000;

   // Tracks the parse state of the current section and the status items it owes.
   class section_status_board;
      logic [7:0]  type_code;
      logic [7:0]  key_limit;
      logic [15:0] value_limit;
      logic [15:0] pair_limit;

      logic [2:0]  header_pos;
      logic        in_value;
      logic [7:0]  key_count;
      logic [15:0] value_count;
      logic [15:0] pair_count;
      logic        bad_char_seen;
      status_type  first_error;

      result_type  status_due_q[$];
      int          mismatches;
      int          items_checked;

      function new();
         type_code   = TYPE_CODE_RST;
         key_limit   = KEY_LIMIT_RST;
         value_limit = VALUE_LIMIT_RST;
         pair_limit  = PAIR_LIMIT_RST;
         mismatches  = 0;
         items_checked = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         header_pos    = '0;
         in_value      = 1'b0;
         key_count     = '0;
         value_count   = '0;
         pair_count    = '0;
         bad_char_seen = 1'b0;
         first_error   = ST_OK;
      endfunction

      function void set_reg(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_TYPE_CODE:   type_code   = value[7:0];
            REG_KEY_LIMIT:   key_limit   = value[7:0];
            REG_VALUE_LIMIT: value_limit = value[15:0];
            REG_PAIR_LIMIT:  pair_limit  = value[15:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return status_due_q.size();
      endfunction

      // Only the first error of a section is kept.
      function void note_error(status_type code);
         if (first_error == ST_OK) first_error = code;
      endfunction

      function void judge_key();
         if (bad_char_seen) note_error(ST_KEY_CHAR);
         else if (key_count >= key_limit) note_error(ST_KEY_LONG);
      endfunction

      function bit letter(logic [7:0] b);
         return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
      endfunction

      function void parse_byte(logic [7:0] b, logic last_flag);
         // Header: type byte, then four skipped length bytes.
         if (header_pos < HDR_BODY) begin
            if (header_pos == 3'd0 && b != type_code) note_error(ST_TYPE);
            header_pos++;
            if (last_flag) note_error(ST_LENGTH);
            return;
         end
         // Key phase.
         if (!in_value) begin
            if (b == 8'h00) begin
               judge_key();
               in_value    = 1'b1;
               value_count = '0;
            end else begin
               if (!letter(b)) bad_char_seen = 1'b1;
               if (key_count != 8'hFF) key_count++;
               if (last_flag) judge_key();
            end
            if (last_flag) note_error(ST_LENGTH);
            return;
         end
         // Value phase.
         if (b == 8'h00) begin
            if (value_count >= value_limit) begin
               note_error(ST_VALUE_LONG);
               return;
            end
            if (pair_count != 16'hFFFF) pair_count++;
            in_value      = 1'b0;
            key_count     = '0;
            bad_char_seen = 1'b0;
            if (last_flag && pair_count > pair_limit) note_error(ST_PAIRS);
         end else begin
            if (value_count != 16'hFFFF) value_count++;
            if (last_flag) begin
               if (value_count >= value_limit) note_error(ST_VALUE_LONG);
               else note_error(ST_LENGTH);
            end
         end
      endfunction

      // Records one accepted byte; the last byte of a section owes a status item.
      function void take_byte(logic [7:0] b, logic last_flag);
         result_type due;
         if (first_error == ST_OK) parse_byte(b, last_flag);
         if (last_flag) begin
            due.status     = first_error;
            due.pair_total = pair_count;
            status_due_q.push_back(due);
            clear_parse();
         end
      endfunction

      // Compares one accepted status item with the oldest one owed.
      function void check_status_item(logic [23:0] tdata);
         result_type due;
         items_checked++;
         if (status_due_q.size() == 0) begin
            $display("%0t: unexpected status item, got status %0d pair_total %0d",
                     $time, tdata[2:0], tdata[18:3]);
            mismatches++;
            return;
         end
         due = status_due_q.pop_front();
         if (tdata[2:0] !== due.status) begin
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, due.status, tdata[2:0]);
            mismatches++;
         end
         if (tdata[18:3] !== due.pair_total) begin
            $display("%0t: pair_total mismatch, expected %0d got %0d",
                     $time, due.pair_total, tdata[18:3]);
            mismatches++;
         end
         if (tdata[23:19] !== 5'd0) begin
            $display("%0t: padding mismatch, expected 0 got %0h", $time, tdata[23:19]);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] data_byte
   logic                  req_tlast;   // last_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [23:0]           rsp_tdata;   // [2:0] status, [18:3] pair_total, zeros above
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   section_status_board board = new();
   int          send_idle_pct = 19;
   int          recv_idle_pct = 45;
   int          bytes_sent    = 0;
   int          sections_sent = 0;
   logic [7:0]  section_bytes[$];

   kv_metadata_section_checker dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Ends a run that hangs.
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   // Result side: checks each accepted status item and stalls at random.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_status_item(rsp_tdata);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Sends one byte, with random gaps ahead of it, and waits until it is taken.
   task automatic send_byte(logic [7:0] b, logic last_flag);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last_flag;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_byte(b, last_flag);
      bytes_sent++;
   endtask

   task automatic send_section();
      foreach (section_bytes[i]) send_byte(section_bytes[i], i == section_bytes.size() - 1);
      sections_sent++;
   endtask

   // One register write; psel stays high so writes run back to back, and apply_setting releases the port.
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_reg(idx, value);
   endtask

   task automatic apply_setting(logic [7:0] t, logic [7:0] k, logic [15:0] v, logic [15:0] p);
      csr_write(REG_TYPE_CODE, 32'(t));
      csr_write(REG_KEY_LIMIT, 32'(k));
      csr_write(REG_VALUE_LIMIT, 32'(v));
      csr_write(REG_PAIR_LIMIT, 32'(p));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every owed status item has come back, then lets the pipeline settle.
   task automatic wait_idle();
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(0, 51);
      if (r < 26) return 8'("a" + r);
      return 8'("A" + r - 26);
   endfunction

   // Lengths are drawn up to the limit when it is small; limits up to 300 are hit only rarely, larger ones never.
   function automatic int pick_len(int limit, int cap);
      if (limit <= cap) return $urandom_range(0, limit);
      if (limit <= 300 && $urandom_range(0, 29) == 0) return $urandom_range(limit - 1, limit);
      return $urandom_range(0, cap);
   endfunction

   // Mostly well-formed sections with random content; some are cut short or pure noise.
   task automatic build_section();
      int npairs;
      int klen;
      int vlen;
      int cut;
      section_bytes.delete();
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 16)) section_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if ($urandom_range(0, 9) == 0) section_bytes.push_back(8'($urandom_range(0, 255)));
      else section_bytes.push_back(board.type_code);
      repeat (4) section_bytes.push_back(8'($urandom_range(0, 255)));
      if (board.pair_limit <= 6) npairs = $urandom_range(0, board.pair_limit + 1);
      else npairs = $urandom_range(0, 4);
      for (int p = 0; p < npairs; p++) begin
         klen = pick_len(board.key_limit, 6);
         for (int k = 0; k < klen; k++) begin
            if ($urandom_range(0, 24) == 0) section_bytes.push_back(8'($urandom_range(1, 255)));
            else section_bytes.push_back(rand_letter());
         end
         section_bytes.push_back(8'h00);
         vlen = pick_len(board.value_limit, 8);
         for (int v = 0; v < vlen; v++) section_bytes.push_back(8'($urandom_range(1, 255)));
         section_bytes.push_back(8'h00);
      end
      if ($urandom_range(0, 4) == 0) begin
         cut = $urandom_range(1, section_bytes.size());
         while (section_bytes.size() > cut) void'(section_bytes.pop_back());
      end
   endtask

   // Short fixed sections for the corner cases under the reset settings.
   task automatic send_directed();
      section_bytes = '{8'hFF};                                   // wrong type byte
      send_section();
      section_bytes = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04};       // empty body
      send_section();
      section_bytes = '{8'h00, 8'h80, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00}; // empty key and value
      send_section();
      section_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "1", 8'h00};   // ends on key terminator
      send_section();
      section_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "Q", "z"};     // ends inside a key
      send_section();
   endtask

   initial begin
      int phase_start;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         // Receiver-heavy idling, then sender-heavy, then none.
         case (ph / 2)
            0: begin send_idle_pct = 19; recv_idle_pct = 45; end
            1: begin send_idle_pct = 45; recv_idle_pct = 19; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (ph)
            0: send_directed();
            1: apply_setting(8'hFF, 8'd1, 16'd1, 16'd1);
            2: apply_setting(8'h00, 8'd255, 16'd65535, 16'd65535);
            5: apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(2, 6)),
                             16'($urandom_range(200, 300)), 16'($urandom_range(2, 4)));
            default: apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(1, 8)),
                                   16'($urandom_range(1, 10)), 16'($urandom_range(1, 5)));
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_section();
            send_section();
         end
         req_tvalid <= 1'b0;
         wait_idle();
      end

      $display("Sent %0d bytes in %0d sections over %0d register settings.",
               bytes_sent, sections_sent, PHASES);
      $display("Checked %0d status items, %0d mismatches.",
               board.items_checked, board.mismatches);
      if (board.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
